>>> design/rfl_pkg.sv
// ----------------------------------------------------------------------------
// rfl_pkg
// Shared types and codes for the ring fifo with loop read.
// ----------------------------------------------------------------------------
package rfl_pkg;

   // default configuration
   localparam int CAPACITY_DEF  = 15;
   localparam int ELEM_BITS_DEF = 32;

   // request modes
   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_PEEK = 2'd1;
   localparam logic [1:0] MODE_POP  = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // request item
   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] write_data;
   } req_type;

   // response item
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_data;
      logic [3:0]  free_slots;
      logic        is_empty;
      logic        is_full;
   } rsp_type;

   // per-item outcome from the index unit
   typedef struct packed {
      logic [1:0] status;
      logic       do_read;
      logic       do_write;
      logic [3:0] free_slots;
      logic       is_empty;
      logic       is_full;
   } idx_info_type;

endpackage

>>> design/ring_fifo_with_loop_read_core.sv
// ----------------------------------------------------------------------------
// ring_fifo_with_loop_read_core
// Ring fifo of CAPACITY+1 slots in a synchronous RAM, one slot kept free,
// with push, peek and pop requests and an optional early read wrap.
// ----------------------------------------------------------------------------
//   channel  direction  payload        handshake
//   req      in         req_type       req_valid / req_ready
//   rsp      out        rsp_type       rsp_valid / rsp_ready
//   csr      in         loop_read bit  csr_valid / csr_ready
//
// per item, the index update and RAM access happen in the accept cycle;
// the RAM read data is loaded into the response register in the lookup state.
// a stalled response holds the block in its lookup state; req_ready is low
// until the response register has been loaded.
// reset is synchronous and clears indexes, loop_read and all valids; the
// slot RAM is not cleared.
// ----------------------------------------------------------------------------
module ring_fifo_with_loop_read_core
   import rfl_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int ELEM_BITS = ELEM_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_wdata
);

   localparam int IW = $clog2(CAPACITY + 1);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_LOOKUP = 1'b1;

   logic           state_ff, state_in;
   logic           req_fire;
   logic           load_rsp;
   logic [IW-1:0]  wr_idx, rd_idx;
   idx_info_type   info;
   idx_info_type   info_ff;
   logic [ELEM_BITS-1:0] rd_elem;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign load_rsp  = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_ready);

   // index unit
   rfl_idx #(
      .CAPACITY (CAPACITY)
   ) u_idx (
      .clock     (clock),
      .reset     (reset),
      .step      (req_fire),
      .mode      (req_data.mode),
      .loop_wr   (csr_valid),
      .loop_data (csr_wdata),
      .wr_idx    (wr_idx),
      .rd_idx    (rd_idx),
      .info      (info)
   );

   // slot storage
   rfl_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (CAPACITY + 1)
   ) u_slots (
      .clock   (clock),
      .wr_en   (req_fire && info.do_write),
      .wr_addr (wr_idx),
      .wr_data (ELEM_BITS'(req_data.write_data)),
      .rd_en   (req_fire && info.do_read),
      .rd_addr (rd_idx),
      .rd_data (rd_elem)
   );

   // sequencing
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_LOOKUP;
         ST_LOOKUP: if (load_rsp) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // response assembly
   always_comb begin
      rsp_in.status     = info_ff.status;
      rsp_in.read_data  = info_ff.do_read ? 32'(rd_elem) : '0;
      rsp_in.free_slots = info_ff.free_slots;
      rsp_in.is_empty   = info_ff.is_empty;
      rsp_in.is_full    = info_ff.is_full;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         info_ff <= info;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> design/rfl_ram.sv
// ----------------------------------------------------------------------------
// rfl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rfl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rfl_idx.sv
// ----------------------------------------------------------------------------
// rfl_idx
// Write and read index registers, loop-read register, full and empty checks
// and the post-step free count.
// ----------------------------------------------------------------------------
module rfl_idx
   import rfl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int IW      = $clog2(CAPACITY + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic [1:0]    mode,
   input  logic          loop_wr,
   input  logic          loop_data,
   output logic [IW-1:0] wr_idx,
   output logic [IW-1:0] rd_idx,
   output idx_info_type  info
);

   localparam int FW = (IW + 1 > 4) ? IW + 1 : 4;
   localparam logic [IW:0] SLOTS = (IW + 1)'(CAPACITY + 1);
   localparam logic [IW:0] CAP   = (IW + 1)'(CAPACITY);

   logic [IW-1:0] wr_idx_ff, wr_idx_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic          loop_ff;

   logic [IW:0]   wr_inc, rd_inc, rd_mod1, rd_mod2;
   logic [IW-1:0] wr_next, rd_next;
   logic          full, empty;
   logic [IW:0]   diff, diff_mod;
   logic [FW-1:0] free_ext;

   // next index candidates
   always_comb begin
      wr_inc  = (IW + 1)'(wr_idx_ff) + (IW + 1)'(1);
      wr_next = (wr_inc >= SLOTS) ? '0 : wr_inc[IW-1:0];
      rd_inc  = (IW + 1)'(rd_idx_ff) + (IW + 1)'(1);
      // loop mode wraps modulo capacity; two steps cover capacity of one
      rd_mod1 = (rd_inc >= CAP) ? rd_inc - CAP : rd_inc;
      rd_mod2 = (rd_mod1 >= CAP) ? rd_mod1 - CAP : rd_mod1;
      if (loop_ff) begin
         rd_next = rd_mod2[IW-1:0];
      end else begin
         rd_next = (rd_inc >= SLOTS) ? '0 : rd_inc[IW-1:0];
      end
      full  = (wr_next == rd_idx_ff);
      empty = (wr_idx_ff == rd_idx_ff);
   end

   // outcome of the current mode
   always_comb begin
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      info.status   = STATUS_OK;
      info.do_read  = 1'b0;
      info.do_write = 1'b0;
      case (mode)
         MODE_PUSH: begin
            if (full) begin
               info.status = STATUS_FULL;
            end else begin
               info.do_write = 1'b1;
               wr_idx_in     = wr_next;
            end
         end
         MODE_PEEK, MODE_POP: begin
            if (empty) begin
               info.status = STATUS_EMPTY;
            end else begin
               info.do_read = 1'b1;
               if (mode == MODE_POP) begin
                  rd_idx_in = rd_next;
               end
            end
         end
         default: begin
         end
      endcase

      // free count after the step
      diff          = (IW + 1)'(rd_idx_in) + SLOTS - (IW + 1)'(wr_idx_in) - (IW + 1)'(1);
      diff_mod      = (diff >= SLOTS) ? diff - SLOTS : diff;
      free_ext      = FW'(diff_mod);
      info.free_slots = free_ext[3:0];
      info.is_full  = (diff_mod == '0);
      info.is_empty = (wr_idx_in == rd_idx_in);
   end

   // index and mode registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         loop_ff   <= 1'b0;
      end else begin
         if (step) begin
            wr_idx_ff <= wr_idx_in;
            rd_idx_ff <= rd_idx_in;
         end
         if (loop_wr) begin
            loop_ff <= loop_data;
         end
      end
   end

   assign wr_idx = wr_idx_ff;
   assign rd_idx = rd_idx_ff;

endmodule
